FILE: src/memory_to_memory_cpu_step_macros.svh
// Assertion macros shared by the memory-to-memory CPU step RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef MEMORY_TO_MEMORY_CPU_STEP_MACROS_SVH
`define MEMORY_TO_MEMORY_CPU_STEP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define M2MCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define M2MCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/m2mcs_pkg.sv
// Shared types and decode helpers for the memory-to-memory CPU step block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package m2mcs_pkg;

	typedef enum logic [3:0] {
		OP_SET   = 4'd0,
		OP_CPY   = 4'd1,
		OP_CPYI  = 4'd2,
		OP_CPYI2 = 4'd3,
		OP_ADD   = 4'd4,
		OP_ADDI  = 4'd5,
		OP_SUBI  = 4'd6,
		OP_JIF   = 4'd7,
		OP_HLT   = 4'd8,
		OP_SYS   = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		FLT_NONE   = 2'd0,
		FLT_OPCODE = 2'd1,
		FLT_ADDR   = 2'd2
	} fault_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH2,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] program_counter;
		logic signed [31:0] dest_value;
		logic               halted;
		logic [1:0]         fault;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;   // clearing pass: zero one word
		logic load;    // take the item, issue first read
		logic fetch2;  // issue second read
		logic exec;    // write back, load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
	} status_t;

	function automatic logic op_known(input logic [3:0] f);
		return f <= OP_SYS;
	endfunction

	// operand_a used as an address
	function automatic logic need_a(input logic [3:0] f);
		logic r;
		case (f)
			OP_CPY, OP_CPYI, OP_CPYI2, OP_ADDI, OP_SUBI, OP_JIF: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// operand_b used as an address
	function automatic logic need_b(input logic [3:0] f);
		logic r;
		case (f)
			OP_SET, OP_CPY, OP_CPYI, OP_CPYI2, OP_ADD, OP_ADDI, OP_SUBI: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/memory_to_memory_cpu_step.sv
// Memory-to-memory CPU step, top level: controller plus datapath.
// Depends on m2mcs_pkg, m2mcs_ctrl and m2mcs_dp.
`timescale 1ns / 1ps

// Executes one instruction per accepted item against a MEM_DEPTH-word data
// memory whose word 0 is the program counter, and returns one result item with
// word 0, the word at operand_b (zero if operand_b is not an address), the
// sticky halt flag and this item's fault code. After reset the block runs a
// clearing pass over every word, zeroing one word a cycle, and does not
// take items until it ends. After that an item is handled in order: accept and
// first read, second read, then execute and write back into the result
// register; the next item is accepted in the cycle after. The order is set by
// the single memory port: an indirect copy needs a pointer read, a data read
// and a write in sequence. A finished result waits in its own register, so a
// new item is taken while the old one is still pending; a second finished
// result holds in execute until the first is taken. Once halted, by HLT or a
// fault, items are still taken and answered but change nothing.

module memory_to_memory_cpu_step #(
	parameter int MEM_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// instruction channel
	input  logic                  instr_valid,
	output logic                  instr_ready,
	input  m2mcs_pkg::in_item_t   instr,
	// result channel
	output logic                  result_valid,
	input  logic                  result_ready,
	output m2mcs_pkg::out_item_t  result
);
	import m2mcs_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencing: clear pass, then load / second read / execute per item
	m2mcs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_ready  (instr_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// memory, fault checks, ALU and result register
	m2mcs_dp #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.instr  (instr),
		.result (result)
	);

endmodule

FILE: src/m2mcs_ctrl.sv
// Sequencer for the memory-to-memory CPU step: clearing pass, two reads, write.
// Depends on m2mcs_pkg.
`timescale 1ns / 1ps

module m2mcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                instr_valid,
	output logic                instr_ready,
	output logic                result_valid,
	input  logic                result_ready,
	input  m2mcs_pkg::status_t  status,
	output m2mcs_pkg::cmd_t     cmd
);
	import m2mcs_pkg::*;

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.exec)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx    = state_q;
		cmd         = '0;
		instr_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last)
					state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				instr_ready = 1'b1;
				if (instr_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_FETCH2;
				end
			end
			ST_FETCH2: begin
				cmd.fetch2 = 1'b1;
				state_nx   = ST_EXEC;
			end
			ST_EXEC: begin
				// hold until the result register is free
				if (out_free) begin
					cmd.exec = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

endmodule

FILE: src/m2mcs_dp.sv
// Datapath for the memory-to-memory CPU step: data memory, operand and
// fault registers, ALU, result register. Depends on m2mcs_pkg and the macros.
`timescale 1ns / 1ps
`include "memory_to_memory_cpu_step_macros.svh"

module m2mcs_dp #(
	parameter int MEM_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  m2mcs_pkg::cmd_t       cmd,
	output m2mcs_pkg::status_t    status,
	input  m2mcs_pkg::in_item_t   instr,
	output m2mcs_pkg::out_item_t  result
);
	import m2mcs_pkg::*;

	localparam int          AW      = $clog2(MEM_DEPTH);
	localparam logic [31:0] DEPTH_W = 32'(MEM_DEPTH);

	function automatic logic addr_ok(input logic [31:0] x);
		return x < DEPTH_W;
	endfunction

	logic [31:0]   mem [MEM_DEPTH];
	logic [31:0]   rd_q;

	logic [3:0]    op_q;
	logic [31:0]   a_q, b_q, d1_q, pc_q;
	fault_t        fault_q;
	logic          skip_q, halt_q;
	logic [AW-1:0] clr_q;
	out_item_t     out_q;

	logic [31:0]   in_a, in_b, addr1, addr2;
	fault_t        early_fault;
	logic          ptr_bad, live;
	logic [31:0]   wr_val, wr_addr, old_b, dest, pc_new;
	logic          do_write, do_store, halt_nx;
	logic [AW-1:0] mem_addr;
	logic          mem_we, rd_en;
	logic [31:0]   mem_wd;

	assign in_a = 32'(instr.operand_a);
	assign in_b = 32'(instr.operand_b);

	// opcode and direct address checks at accept
	always_comb begin
		if (!op_known(instr.func))
			early_fault = FLT_OPCODE;
		else if ((need_a(instr.func) && !addr_ok(in_a)) ||
		         (need_b(instr.func) && !addr_ok(in_b)))
			early_fault = FLT_ADDR;
		else
			early_fault = FLT_NONE;
	end

	assign addr1   = (instr.func == OP_CPYI2 || instr.func == OP_ADD) ? in_b : in_a;
	assign live    = !skip_q && fault_q == FLT_NONE;
	assign ptr_bad = (op_q == OP_CPYI || op_q == OP_CPYI2) && !addr_ok(rd_q);

	// second read: through the pointer for CPYI, source for CPYI2, else word b
	always_comb begin
		if (op_q == OP_CPYI && live && !ptr_bad)
			addr2 = rd_q;
		else if (op_q == OP_CPYI2)
			addr2 = a_q;
		else
			addr2 = b_q;
	end

	// execute: d1_q is the first read, rd_q the second
	always_comb begin
		wr_val   = '0;
		wr_addr  = b_q;
		do_write = 1'b0;
		case (op_q)
			OP_SET: begin
				wr_val   = a_q;
				do_write = 1'b1;
			end
			OP_CPY: begin
				wr_val   = d1_q;
				do_write = 1'b1;
			end
			OP_CPYI: begin
				wr_val   = rd_q;
				do_write = 1'b1;
			end
			OP_CPYI2: begin
				wr_val   = rd_q;
				wr_addr  = d1_q;
				do_write = 1'b1;
			end
			OP_ADD: begin
				wr_val   = d1_q + a_q;
				do_write = 1'b1;
			end
			OP_ADDI: begin
				wr_val   = rd_q + d1_q;
				do_write = 1'b1;
			end
			OP_SUBI: begin
				wr_val   = rd_q - d1_q;
				do_write = 1'b1;
			end
			OP_JIF: begin
				wr_val   = b_q;
				wr_addr  = '0;
				do_write = (d1_q == '0) || d1_q[31];
			end
			default: begin
				do_write = 1'b0;
			end
		endcase
	end

	assign do_store = do_write && live;
	assign halt_nx  = halt_q || (fault_q != FLT_NONE) || (op_q == OP_HLT && live);
	assign old_b    = (op_q == OP_CPYI2) ? d1_q : rd_q;
	assign pc_new   = (do_store && wr_addr == '0) ? wr_val : pc_q;

	always_comb begin
		if (!addr_ok(b_q))
			dest = '0;
		else if (do_store && wr_addr == b_q)
			dest = wr_val;
		else
			dest = old_b;
	end

	// single-port memory access
	always_comb begin
		if (cmd.clear)
			mem_addr = clr_q;
		else if (cmd.load)
			mem_addr = addr1[AW-1:0];
		else if (cmd.fetch2)
			mem_addr = addr2[AW-1:0];
		else
			mem_addr = wr_addr[AW-1:0];
	end

	assign mem_we = cmd.clear || (cmd.exec && do_store);
	assign mem_wd = cmd.clear ? '0 : wr_val;
	assign rd_en  = cmd.load || cmd.fetch2;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wd;
		if (rd_en)
			rd_q <= mem[mem_addr];
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= instr.func;
			a_q  <= in_a;
			b_q  <= in_b;
		end
		if (cmd.fetch2)
			d1_q <= rd_q;
		if (cmd.exec)
			out_q <= '{program_counter: pc_new, dest_value: dest,
			           halted: halt_nx, fault: fault_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_q  <= 1'b0;
			skip_q  <= 1'b0;
			fault_q <= FLT_NONE;
			pc_q    <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clear)
				clr_q <= clr_q + 1'b1;
			if (cmd.load) begin
				skip_q  <= halt_q;
				fault_q <= halt_q ? FLT_NONE : early_fault;
			end
			if (cmd.fetch2 && live && ptr_bad)
				fault_q <= FLT_ADDR;
			if (cmd.exec) begin
				halt_q <= halt_nx;
				pc_q   <= pc_new;
			end
		end
	end

	assign status.clear_last = (clr_q == AW'(MEM_DEPTH - 1));
	assign result            = out_q;

	`M2MCS_ASSERT_NOW(a_no_write_when_dead, cmd.exec && mem_we, !skip_q && fault_q == FLT_NONE, "write after halt or fault")
	`M2MCS_ASSERT_NOW(a_write_in_range, mem_we && !cmd.clear, addr_ok(wr_addr), "write address out of range")
	`M2MCS_ASSERT_NEXT(a_halt_sticky, halt_q, halt_q, "halt flag cleared")
	`M2MCS_ASSERT_NEXT(a_fault_halts, cmd.exec && fault_q != FLT_NONE, halt_q && out_q.halted, "fault did not halt")

endmodule
